// ===== design/afk_pkg.sv =====
`default_nettype none

package afk_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 8;

    localparam int ATAN_ENTRIES = 24;

    // CORDIC datapath: Q4.30 vector, residue in 2^32 units per turn
    localparam int XW = 34;
    localparam int ZW = 34;

    localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

    localparam longint K_LOFF_Q16 = 64'sd18564528;
    localparam longint K_D_Q16    = 64'sd1871176;
    localparam longint K_XOFF_Q16 = 64'sd17281843;
    localparam longint K_YOFF_Q16 = 64'sd1966080;

    // link length and offset arm widths, sized for every fraction setting
    localparam int LW = 26;
    localparam int DW = 22;

    typedef struct packed {
        logic signed [15:0] joint_angle;
        logic signed [23:0] extension;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] cosine;
        logic signed [15:0] sine;
        logic signed [23:0] extension;
    } trig_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] dx_dangle;
        logic signed [15:0] dx_dext;
        logic signed [31:0] dy_dangle;
        logic signed [15:0] dy_dext;
    } result_t;

    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic signed [ZW-1:0] v;
        unique case (i)
            0:       v = ZW'(536870912);
            1:       v = ZW'(316933406);
            2:       v = ZW'(167458907);
            3:       v = ZW'(85004756);
            4:       v = ZW'(42667331);
            5:       v = ZW'(21354465);
            6:       v = ZW'(10679838);
            7:       v = ZW'(5340245);
            8:       v = ZW'(2670163);
            9:       v = ZW'(1335087);
            10:      v = ZW'(667544);
            11:      v = ZW'(333772);
            12:      v = ZW'(166886);
            13:      v = ZW'(83443);
            14:      v = ZW'(41722);
            15:      v = ZW'(20861);
            16:      v = ZW'(10430);
            17:      v = ZW'(5215);
            18:      v = ZW'(2608);
            19:      v = ZW'(1304);
            20:      v = ZW'(652);
            21:      v = ZW'(326);
            22:      v = ZW'(163);
            23:      v = ZW'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q16 constant rounded half up to the given fraction width
    function automatic logic signed [31:0] konst(input longint q16, input int frac);
        longint sh;
        longint v;
        sh = 64'(16 - frac);
        if (sh == 0)
            v = q16;
        else
            v = (q16 + (longint'(1) << (sh - 1))) >>> sh;
        return 32'(v);
    endfunction

endpackage

`default_nettype wire

// ===== design/afk_stream_if.sv =====
`default_nettype none

interface afk_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/afk_cordic.sv =====
`default_nettype none

module afk_cordic #(
    parameter int CORDIC_STAGES = afk_pkg::CORDIC_STAGES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    afk_stream_if.sink   sample,
    afk_stream_if.source trig
);

    localparam int N  = CORDIC_STAGES;
    localparam int XW = afk_pkg::XW;
    localparam int ZW = afk_pkg::ZW;

    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(longint'(1) << 31);
    localparam logic signed [ZW-1:0] QUARTER   = ZW'(longint'(1) << 30);
    localparam logic signed [XW-1:0] GAIN      = XW'(afk_pkg::CORDIC_GAIN_Q30);
    localparam logic signed [XW-1:0] HALF_LSB  = XW'(16384);

    logic en;

    logic [N:0]             valid_reg;
    logic [N:0]             valid_next;
    logic [N:0]             flip_reg;
    logic [N:0]             flip_next;
    logic signed [XW-1:0]   x_reg    [0:N];
    logic signed [XW-1:0]   x_next   [0:N];
    logic signed [XW-1:0]   y_reg    [0:N];
    logic signed [XW-1:0]   y_next   [0:N];
    logic signed [ZW-1:0]   z_reg    [0:N];
    logic signed [ZW-1:0]   z_next   [0:N];
    logic signed [23:0]     ext_reg  [0:N];
    logic signed [23:0]     ext_next [0:N];

    logic            trig_valid_reg;
    afk_pkg::trig_t  trig_data_reg;
    afk_pkg::trig_t  trig_data_next;

    function automatic logic signed [15:0] sat16(input logic signed [XW-1:0] v);
        logic signed [15:0] r;
        if (v > XW'(32767))
            r = 16'sh7fff;
        else if (v < -XW'(32768))
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    assign en           = !trig_valid_reg || trig.ready;
    assign sample.ready = en;
    assign trig.valid   = trig_valid_reg;
    assign trig.data    = trig_data_reg;

    always_comb
    begin
        logic signed [15:0]   angle;
        logic signed [ZW-1:0] z0;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [XW-1:0] xf;
        logic signed [XW-1:0] yf;

        angle = sample.data.joint_angle;
        z0    = {{(ZW-32){angle[15]}}, angle, 16'b0};

        valid_next[0] = sample.valid;
        x_next[0]     = GAIN;
        y_next[0]     = '0;
        ext_next[0]   = sample.data.extension;
        if (angle > 16'sd16384)
        begin
            z_next[0]    = z0 - HALF_TURN;
            flip_next[0] = 1'b1;
        end
        else if (angle < -16'sd16384)
        begin
            z_next[0]    = z0 + HALF_TURN;
            flip_next[0] = 1'b1;
        end
        else
        begin
            z_next[0]    = z0;
            flip_next[0] = 1'b0;
        end

        for (int k = 1; k <= N; k++)
        begin
            dx            = x_reg[k-1] >>> (k - 1);
            dy            = y_reg[k-1] >>> (k - 1);
            valid_next[k] = valid_reg[k-1];
            flip_next[k]  = flip_reg[k-1];
            ext_next[k]   = ext_reg[k-1];
            if (!z_reg[k-1][ZW-1])
            begin
                x_next[k] = x_reg[k-1] - dy;
                y_next[k] = y_reg[k-1] + dx;
                z_next[k] = z_reg[k-1] - afk_pkg::atan_step(k - 1);
            end
            else
            begin
                x_next[k] = x_reg[k-1] + dy;
                y_next[k] = y_reg[k-1] - dx;
                z_next[k] = z_reg[k-1] + afk_pkg::atan_step(k - 1);
            end
        end

        xf = flip_reg[N] ? -x_reg[N] : x_reg[N];
        yf = flip_reg[N] ? -y_reg[N] : y_reg[N];
        trig_data_next.cosine    = sat16((xf + HALF_LSB) >>> 15);
        trig_data_next.sine      = sat16((yf + HALF_LSB) >>> 15);
        trig_data_next.extension = ext_reg[N];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            trig_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg      <= valid_next;
            trig_valid_reg <= valid_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flip_reg <= flip_next;
            for (int k = 0; k <= N; k++)
            begin
                x_reg[k]   <= x_next[k];
                y_reg[k]   <= y_next[k];
                z_reg[k]   <= z_next[k];
                ext_reg[k] <= ext_next[k];
            end
            trig_data_reg <= trig_data_next;
        end
    end

`ifndef SYNTHESIS
    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> (z_reg[0] <= QUARTER && z_reg[0] >= -QUARTER))
        else $error("pre-rotated angle outside a quarter turn");

    a_unit_norm: assert property (@(posedge clk) disable iff (!rst_n)
        trig_valid_reg |->
            ((longint'(trig_data_reg.cosine) * longint'(trig_data_reg.cosine)
              + longint'(trig_data_reg.sine) * longint'(trig_data_reg.sine)
              <= (longint'(1) << 30) + (longint'(1) << 24)) &&
             (longint'(trig_data_reg.cosine) * longint'(trig_data_reg.cosine)
              + longint'(trig_data_reg.sine) * longint'(trig_data_reg.sine)
              >= (longint'(1) << 30) - (longint'(1) << 24))))
        else $error("cosine and sine off the unit circle");
`endif

endmodule

`default_nettype wire

// ===== design/afk_jacobian.sv =====
`default_nettype none

module afk_jacobian #(
    parameter int FRAC_BITS = afk_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    afk_stream_if.sink   trig,
    afk_stream_if.source result
);

    localparam int LW   = afk_pkg::LW;
    localparam int DW   = afk_pkg::DW;
    localparam int PLW  = LW + 16;
    localparam int PDW  = DW + 16;
    localparam int ACCW = PLW + 2;
    localparam int RW   = ACCW - 15;

    localparam logic signed [31:0] L_OFF_W = afk_pkg::konst(afk_pkg::K_LOFF_Q16, FRAC_BITS);
    localparam logic signed [31:0] D_W     = afk_pkg::konst(afk_pkg::K_D_Q16, FRAC_BITS);
    localparam logic signed [31:0] X_OFF   = afk_pkg::konst(afk_pkg::K_XOFF_Q16, FRAC_BITS);
    localparam logic signed [31:0] Y_OFF   = afk_pkg::konst(afk_pkg::K_YOFF_Q16, FRAC_BITS);
    localparam logic signed [LW-1:0] L_OFF = L_OFF_W[LW-1:0];
    localparam logic signed [DW-1:0] D_K   = D_W[DW-1:0];
    localparam logic signed [ACCW-1:0] ROUND = ACCW'(16384);

    logic en;
    logic [3:0] valid_reg;

    logic signed [LW-1:0]  l_reg;
    logic signed [15:0]    c1_reg;
    logic signed [15:0]    s1_reg;

    logic signed [PLW-1:0] plc_reg;
    logic signed [PLW-1:0] pls_reg;
    logic signed [PDW-1:0] pdc_reg;
    logic signed [PDW-1:0] pds_reg;
    logic signed [15:0]    c2_reg;
    logic signed [15:0]    s2_reg;

    logic signed [ACCW-1:0] acc_x_next;
    logic signed [ACCW-1:0] acc_y_next;
    logic signed [ACCW-1:0] acc_j_next;
    logic signed [RW-1:0]   sx_reg;
    logic signed [RW-1:0]   sy_reg;
    logic signed [RW-1:0]   sj_reg;
    logic signed [15:0]     c3_reg;
    logic signed [15:0]     s3_reg;

    afk_pkg::result_t result_reg;
    afk_pkg::result_t result_next;

    assign en           = !valid_reg[3] || result.ready;
    assign trig.ready   = en;
    assign result.valid = valid_reg[3];
    assign result.data  = result_reg;

    always_comb
    begin
        acc_x_next = ACCW'(plc_reg) + ACCW'(pds_reg) + ROUND;
        acc_y_next = ACCW'(pls_reg) - ACCW'(pdc_reg) + ROUND;
        acc_j_next = ACCW'(pdc_reg) - ACCW'(pls_reg) + ROUND;

        // sums stay inside 32 bits for every fraction setting: clamp is a sign extension
        result_next.pos_x     = 32'(sx_reg) - X_OFF;
        result_next.pos_y     = 32'(sy_reg) + Y_OFF;
        result_next.dx_dangle = 32'(sj_reg);
        result_next.dx_dext   = c3_reg;
        result_next.dy_dangle = 32'(sx_reg);
        result_next.dy_dext   = s3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], trig.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg  <= LW'(trig.data.extension) + L_OFF;
            c1_reg <= trig.data.cosine;
            s1_reg <= trig.data.sine;

            plc_reg <= l_reg * c1_reg;
            pls_reg <= l_reg * s1_reg;
            pdc_reg <= D_K * c1_reg;
            pds_reg <= D_K * s1_reg;
            c2_reg  <= c1_reg;
            s2_reg  <= s1_reg;

            sx_reg <= acc_x_next[ACCW-1:15];
            sy_reg <= acc_y_next[ACCW-1:15];
            sj_reg <= acc_j_next[ACCW-1:15];
            c3_reg <= c2_reg;
            s3_reg <= s2_reg;

            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    a_x_offset: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> (result_reg.pos_x == result_reg.dy_dangle - X_OFF))
        else $error("x position and its angle derivative disagree");

    a_y_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |->
            ((result_reg.pos_y - Y_OFF + result_reg.dx_dangle) == 32'sd0 ||
             (result_reg.pos_y - Y_OFF + result_reg.dx_dangle) == 32'sd1))
        else $error("y position and dx over angle are not negated pairs");
`endif

endmodule

`default_nettype wire

// ===== design/arm_forward_kinematics_jacobian.sv =====
// Forward kinematics and Jacobian of a rotary joint followed by a prismatic joint.
// Channel sample carries joint_angle (binary angle, 32768 = pi) and extension
// (signed, FRAC_BITS fraction bits); channel result carries tool position x,y and
// the 2x2 Jacobian (angle terms in the position format, cosine and sine in Q1.15).
// A transaction completes on a rising clk edge with valid and ready both high.
// Pipeline registers: one pre-rotation register, one register per CORDIC rotation,
// a rounding register, then link length, multiply, sum and offset registers.
// Throughput is one transaction per cycle while results are taken; the unrolled
// CORDIC and the four parallel multipliers each take a new sample every unstalled clock.
// rst_n clears all stage valid bits asynchronously; result.valid drops at once.
// When the receiver stalls, the result holds in the output register and the
// pipeline freezes behind it; sample.ready stays high while the output
// register is empty, so nothing is dropped or repeated.
`default_nettype none

module arm_forward_kinematics_jacobian #(
    parameter int CORDIC_STAGES = afk_pkg::CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = afk_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    afk_stream_if.sink   sample,
    afk_stream_if.source result
);

    afk_stream_if #(.payload_t(afk_pkg::trig_t)) trig_ch ();

    afk_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .trig   (trig_ch.source)
    );

    afk_jacobian #(
        .FRAC_BITS(FRAC_BITS)
    ) u_jacobian (
        .clk    (clk),
        .rst_n  (rst_n),
        .trig   (trig_ch.sink),
        .result (result)
    );

endmodule

`default_nettype wire

// ===== tb/afk_kinematics_checker.sv =====
module afk_kinematics_checker #(
    parameter int CORDIC_STAGES = afk_pkg::CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = afk_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    input  logic             sample_ready,
    input  afk_pkg::sample_t sample_data,
    input  logic             result_valid,
    input  logic             result_ready,
    input  afk_pkg::result_t result_data,
    output int               fail_count,
    output int               pending
);
    import afk_pkg::*;

    localparam longint ATAN_TURN32 [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    result_t pose_q[$];
    int      mismatches = 0;

    function automatic longint floor_shr(input longint v, input int sh);
        return v >>> sh;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Q16 constant to FRAC_BITS, round half up
    function automatic longint q16_to_frac(input longint q16);
        int sh;
        sh = 16 - FRAC_BITS;
        if (sh == 0)
            return q16;
        return floor_shr(q16 + (longint'(1) << (sh - 1)), sh);
    endfunction

    function automatic result_t arm_pose(input sample_t smp);
        longint  ang;
        longint  ext;
        longint  z;
        longint  x;
        longint  y;
        longint  dx;
        longint  dy;
        longint  cs;
        longint  sn;
        longint  len;
        longint  arm;
        longint  sum_x;
        longint  sum_y;
        longint  sum_j;
        bit      flip;
        result_t r;
        ang  = longint'(smp.joint_angle);
        ext  = longint'(smp.extension);
        z    = ang * 65536;
        flip = 1'b0;
        if (ang > 16384) begin
            z    = z - (longint'(1) << 31);
            flip = 1'b1;
        end else if (ang < -16384) begin
            z    = z + (longint'(1) << 31);
            flip = 1'b1;
        end
        x = CORDIC_GAIN_Q30;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURN32[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURN32[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = clamp(floor_shr(x + 16384, 15), -32768, 32767);
        sn = clamp(floor_shr(y + 16384, 15), -32768, 32767);

        len   = ext + q16_to_frac(K_LOFF_Q16);
        arm   = q16_to_frac(K_D_Q16);
        sum_x = floor_shr(len * cs + arm * sn + 16384, 15);
        sum_y = floor_shr(len * sn - arm * cs + 16384, 15);
        sum_j = floor_shr(arm * cs - len * sn + 16384, 15);

        r.pos_x     = 32'(clamp(sum_x - q16_to_frac(K_XOFF_Q16), -64'sd2147483648, 64'sd2147483647));
        r.pos_y     = 32'(clamp(sum_y + q16_to_frac(K_YOFF_Q16), -64'sd2147483648, 64'sd2147483647));
        r.dx_dangle = 32'(clamp(sum_j, -64'sd2147483648, 64'sd2147483647));
        r.dx_dext   = 16'(cs);
        r.dy_dangle = 32'(clamp(sum_x, -64'sd2147483648, 64'sd2147483647));
        r.dy_dext   = 16'(sn);
        return r;
    endfunction

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            if (result_valid && result_ready) begin
                if (pose_q.size() == 0) begin
                    $error("result transaction with no expected pose");
                    mismatches++;
                end else begin
                    want = pose_q.pop_front();
                    check_field("pos_x", want.pos_x, result_data.pos_x);
                    check_field("pos_y", want.pos_y, result_data.pos_y);
                    check_field("dx_dangle", want.dx_dangle, result_data.dx_dangle);
                    check_field("dx_dext", want.dx_dext, result_data.dx_dext);
                    check_field("dy_dangle", want.dy_dangle, result_data.dy_dangle);
                    check_field("dy_dext", want.dy_dext, result_data.dy_dext);
                end
            end
            if (sample_valid && sample_ready)
                pose_q.push_back(arm_pose(sample_data));
        end
        pending    <= pose_q.size();
        fail_count <= mismatches;
    end

endmodule

// ===== tb/tb_arm_forward_kinematics_jacobian.sv =====
module tb_arm_forward_kinematics_jacobian;
    import afk_pkg::*;

    localparam int STAGES       = CORDIC_STAGES_DEF;
    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int RANDOM_ITEMS = 650;
    localparam int DRAIN_CYCLES = STAGES + 20;

    logic clk;
    logic rst_n;
    int   cyc = 0;
    int   fail_count;
    int   pending;

    afk_stream_if #(.payload_t(sample_t)) sample_ch ();
    afk_stream_if #(.payload_t(result_t)) result_ch ();

    arm_forward_kinematics_jacobian #(
        .CORDIC_STAGES(STAGES),
        .FRAC_BITS    (FRAC)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_ch),
        .result(result_ch)
    );

    afk_kinematics_checker #(
        .CORDIC_STAGES(STAGES),
        .FRAC_BITS    (FRAC)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_ch.valid),
        .sample_ready(sample_ch.ready),
        .sample_data (sample_ch.data),
        .result_valid(result_ch.valid),
        .result_ready(result_ch.ready),
        .result_data (result_ch.data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    function automatic bit no_idle();
        return cyc >= 300 && cyc < 550;
    endfunction

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= no_idle() || ($urandom_range(99) >= 19);
        end
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    function automatic sample_t make_sample(input int ang, input int ext);
        sample_t s;
        s.joint_angle = 16'(ang);
        s.extension   = 24'(ext);
        return s;
    endfunction

    function automatic sample_t random_sample();
        int pick;
        int edge_angles [10] = '{16383, 16384, 16385, -16383, -16384, -16385,
                                 32767, -32768, 0, -1};
        pick = $urandom_range(99);
        if (pick < 60)
            return make_sample($urandom, $urandom);
        if (pick < 85)
            return make_sample($urandom, int'($urandom_range(512000)) - 256000);
        return make_sample(edge_angles[$urandom_range(9)], $urandom);
    endfunction

    task automatic send_sample(input sample_t s);
        while (!no_idle() && $urandom_range(99) < 19)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= s;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_sample(make_sample(0, 0));
        send_sample(make_sample(16384, 0));
        send_sample(make_sample(16385, 0));
        send_sample(make_sample(-16384, 0));
        send_sample(make_sample(-16385, 0));
        send_sample(make_sample(32767, 0));
        send_sample(make_sample(-32768, 0));
        send_sample(make_sample(8192, 25600));
        send_sample(make_sample(-8192, -25600));
        send_sample(make_sample(1, 8388607));
        send_sample(make_sample(-1, -8388608));
        send_sample(make_sample(32767, 8388607));
        send_sample(make_sample(-32768, -8388608));
        send_sample(make_sample(16384, 8388607));
        send_sample(make_sample(-16384, -8388608));
        // zero link length
        send_sample(make_sample(0, -72518));
        send_sample(make_sample(24576, -72518));
        send_sample(make_sample(24576, 100));
        send_sample(make_sample(-24576, -100));
        send_sample(make_sample(12345, 1));
        send_sample(make_sample(-12345, 255));

        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_sample(random_sample());

        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
design/afk_pkg.sv
design/afk_stream_if.sv
design/afk_cordic.sv
design/afk_jacobian.sv
design/arm_forward_kinematics_jacobian.sv
tb/afk_kinematics_checker.sv
tb/tb_arm_forward_kinematics_jacobian.sv
